// ===== src/sbe_pkg.sv =====
// Shared types, opcodes and decode helpers of the stack bytecode execute unit.
// No dependencies; used by sbe_div, sbe_alu and the top level.
`timescale 1ns / 1ps
package sbe_pkg;

   localparam int STACK_DEPTH_DEF  = 64;
   localparam int LOCAL_SLOTS_DEF  = 32;
   localparam int GLOBAL_SLOTS_DEF = 256;
   localparam int THREAD_SLOTS_DEF = 64;
   localparam int SPECIAL_SLOTS    = 256;
   localparam logic [15:0] GUARD_RESET = 16'd10000;
   localparam int REQ_W = 48;
   localparam int CSR_W = 16;

   localparam logic [5:0] OP_START  = 6'd0;
   localparam logic [5:0] OP_NOP    = 6'd1;
   localparam logic [5:0] OP_POP    = 6'd2;
   localparam logic [5:0] OP_DUP    = 6'd3;
   localparam logic [5:0] OP_GLD    = 6'd4;
   localparam logic [5:0] OP_GST    = 6'd5;
   localparam logic [5:0] OP_LLD    = 6'd6;
   localparam logic [5:0] OP_LST    = 6'd7;
   localparam logic [5:0] OP_SLD    = 6'd8;
   localparam logic [5:0] OP_TLD    = 6'd9;
   localparam logic [5:0] OP_C32    = 6'd10;
   localparam logic [5:0] OP_C8     = 6'd11;
   localparam logic [5:0] OP_ADD    = 6'd12;
   localparam logic [5:0] OP_SUB    = 6'd13;
   localparam logic [5:0] OP_MUL    = 6'd14;
   localparam logic [5:0] OP_DIV    = 6'd15;
   localparam logic [5:0] OP_MOD    = 6'd16;
   localparam logic [5:0] OP_AND    = 6'd17;
   localparam logic [5:0] OP_OR     = 6'd18;
   localparam logic [5:0] OP_XOR    = 6'd19;
   localparam logic [5:0] OP_SHR    = 6'd20;
   localparam logic [5:0] OP_SHL    = 6'd21;
   localparam logic [5:0] OP_LNOT   = 6'd22;
   localparam logic [5:0] OP_LAND   = 6'd23;
   localparam logic [5:0] OP_LOR    = 6'd24;
   localparam logic [5:0] OP_LT     = 6'd25;
   localparam logic [5:0] OP_LE     = 6'd26;
   localparam logic [5:0] OP_GT     = 6'd27;
   localparam logic [5:0] OP_GE     = 6'd28;
   localparam logic [5:0] OP_EQ     = 6'd29;
   localparam logic [5:0] OP_NE     = 6'd30;
   localparam logic [5:0] OP_NEG    = 6'd31;
   localparam logic [5:0] OP_NOT    = 6'd32;
   localparam logic [5:0] OP_JZ     = 6'd33;
   localparam logic [5:0] OP_JNZ    = 6'd34;
   localparam logic [5:0] OP_JMP    = 6'd35;
   localparam logic [5:0] OP_LJZ    = 6'd36;
   localparam logic [5:0] OP_LJNZ   = 6'd37;
   localparam logic [5:0] OP_LJMP   = 6'd38;
   localparam logic [5:0] OP_LOOP   = 6'd39;
   localparam logic [5:0] OP_RET    = 6'd40;
   localparam logic [5:0] OP_HOSTWR = 6'd41;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FAULT = 2'd1;
   localparam logic [1:0] ST_GUARD = 2'd2;
   localparam logic [1:0] ST_DONE  = 2'd3;

   localparam logic [1:0] BANK_GLOBAL  = 2'd0;
   localparam logic [1:0] BANK_SPECIAL = 2'd1;
   localparam logic [1:0] BANK_THREAD  = 2'd2;

   typedef struct packed {
      logic       ok;
      logic [1:0] need;
      logic [1:0] grow;
      logic [2:0] len;
   } shape_type;

   typedef struct packed {
      logic start;
      logic is_mod;
   } div_ctl_type;

   function automatic logic [31:0] sext8(input logic [7:0] v);
      sext8 = {{24{v[7]}}, v};
   endfunction

   function automatic shape_type shape(input logic [5:0] mode, input logic ret_int);
      shape_type s;
      s = '{ok: 1'b1, need: 2'd0, grow: 2'd0, len: 3'd1};
      case (mode)
         OP_NOP, OP_LOOP: ;
         OP_POP: s.need = 2'd1;
         OP_DUP: begin s.need = 2'd1; s.grow = 2'd2; end
         OP_GLD, OP_LLD, OP_SLD, OP_TLD, OP_C8: begin s.grow = 2'd1; s.len = 3'd2; end
         OP_GST, OP_LST: begin s.need = 2'd1; s.len = 3'd2; end
         OP_C32: begin s.grow = 2'd1; s.len = 3'd5; end
         OP_LNOT, OP_NEG, OP_NOT: begin s.need = 2'd1; s.grow = 2'd1; end
         OP_JZ, OP_JNZ: begin s.need = 2'd1; s.len = 3'd2; end
         OP_JMP: s.len = 3'd2;
         OP_LJZ, OP_LJNZ: begin s.need = 2'd1; s.len = 3'd5; end
         OP_LJMP: s.len = 3'd5;
         OP_RET: s.need = {1'b0, ret_int};
         default: begin
            if (mode >= OP_ADD && mode <= OP_NE) begin
               s.need = 2'd2;
               s.grow = 2'd1;
            end else begin
               s.ok = 1'b0;
            end
         end
      endcase
      shape = s;
   endfunction

endpackage

// ===== src/sbe_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module sbe_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

// ===== src/sbe_div.sv =====
// Iterative signed 32-bit divider, one quotient bit per cycle.
// Depends on sbe_pkg for the control struct.
`timescale 1ns / 1ps
module sbe_div (
   input  logic                 clock,
   input  logic                 reset,
   input  sbe_pkg::div_ctl_type ctl,
   input  logic [31:0]          dividend,
   input  logic [31:0]          divisor,
   output logic                 busy,
   output logic                 done,
   output logic [31:0]          result
);
   import sbe_pkg::*;

   logic        busy_ff, busy_in, done_ff, done_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [32:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in, den_ff, den_in, res_ff, res_in;
   logic        qneg_ff, qneg_in, rneg_ff, rneg_in, mod_ff, mod_in, zero_ff, zero_in;
   logic [32:0] rem_sh;
   logic [31:0] q_fix, r_fix;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      res_in  = res_ff;
      qneg_in = qneg_ff;
      rneg_in = rneg_ff;
      mod_in  = mod_ff;
      zero_in = zero_ff;
      rem_sh  = {rem_ff[31:0], quo_ff[31]};
      q_fix   = qneg_ff ? (32'd0 - quo_ff) : quo_ff;
      r_fix   = rneg_ff ? (32'd0 - rem_ff[31:0]) : rem_ff[31:0];
      if (ctl.start) begin
         busy_in = 1'b1;
         cnt_in  = 6'd0;
         rem_in  = 33'd0;
         quo_in  = dividend[31] ? (32'd0 - dividend) : dividend;
         den_in  = divisor[31] ? (32'd0 - divisor) : divisor;
         qneg_in = dividend[31] ^ divisor[31];
         rneg_in = dividend[31];
         mod_in  = ctl.is_mod;
         zero_in = (divisor == 32'd0);
      end else if (busy_ff) begin
         if (cnt_ff == 6'd32) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            res_in  = zero_ff ? 32'd0 : (mod_ff ? r_fix : q_fix);
         end else begin
            cnt_in = cnt_ff + 6'd1;
            if (rem_sh >= {1'b0, den_ff}) begin
               rem_in = rem_sh - {1'b0, den_ff};
               quo_in = {quo_ff[30:0], 1'b1};
            end else begin
               rem_in = rem_sh;
               quo_in = {quo_ff[30:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      den_ff  <= den_in;
      res_ff  <= res_in;
      qneg_ff <= qneg_in;
      rneg_ff <= rneg_in;
      mod_ff  <= mod_in;
      zero_ff <= zero_in;
   end

   assign busy   = busy_ff;
   assign done   = done_ff;
   assign result = res_ff;
endmodule

// ===== src/sbe_alu.sv =====
// Combinational two-operand ALU for the non-dividing binary opcodes.
// Depends on sbe_pkg for opcode names.
`timescale 1ns / 1ps
module sbe_alu (
   input  logic [5:0]  mode,
   input  logic [31:0] a,
   input  logic [31:0] b,
   output logic [31:0] y
);
   import sbe_pkg::*;

   logic signed [31:0] sa, sb;

   assign sa   = a;
   assign sb   = b;

   always_comb begin
      case (mode)
         OP_ADD:  y = a + b;
         OP_SUB:  y = a - b;
         OP_MUL:  y = a * b;
         OP_AND:  y = a & b;
         OP_OR:   y = a | b;
         OP_XOR:  y = a ^ b;
         OP_SHR:  y = sa >>> b[4:0];
         OP_SHL:  y = a << b[4:0];
         OP_LAND: y = {31'd0, (a != 32'd0) && (b != 32'd0)};
         OP_LOR:  y = {31'd0, (a != 32'd0) || (b != 32'd0)};
         OP_LT:   y = {31'd0, sa < sb};
         OP_LE:   y = {31'd0, sa <= sb};
         OP_GT:   y = {31'd0, sa > sb};
         OP_GE:   y = {31'd0, sa >= sb};
         OP_EQ:   y = {31'd0, a == b};
         default: y = {31'd0, a != b};
      endcase
   end
endmodule

// ===== src/stack_bytecode_execute_unit.sv =====
// Top level of the stack bytecode execute unit: sequencer, stack and bank RAMs.
// Depends on sbe_pkg, sbe_ram, sbe_div and sbe_alu.
`timescale 1ns / 1ps
// Usage:
//  req channel: one decoded instruction per transfer (mode, slot_index,
//    immediate, bank). rsp channel: exactly one result per instruction, in order.
//  csr channel: writes loop_guard_limit; write only while the unit is idle.
//  Sequence: after accept the unit reads the top, reads the second, executes,
//    reads the new top and presents the result; divide and modulo add the
//    iterative divider between execute and the new-top read. One item is in
//    work at a time, so no new instruction is taken until the result is
//    presented; the single read port of the operand stack RAM sets the order.
//  The next request is taken while a finished result still waits in the rsp
//  register; a stalled receiver holds the unit only when the next result is
//  ready to be presented.
//  Reset: the unit sweeps the global, special and thread banks to zero, one
//  entry per cycle across all 256 special slots; req_tready stays low during the sweep.
//  The stack empties, all locals read as zero and the guard count reloads.
module stack_bytecode_execute_unit #(
   parameter int STACK_DEPTH  = sbe_pkg::STACK_DEPTH_DEF,
   parameter int LOCAL_SLOTS  = sbe_pkg::LOCAL_SLOTS_DEF,
   parameter int GLOBAL_SLOTS = sbe_pkg::GLOBAL_SLOTS_DEF,
   parameter int THREAD_SLOTS = sbe_pkg::THREAD_SLOTS_DEF,
   localparam int SPW   = $clog2(STACK_DEPTH + 1),
   localparam int RSP_W = ((67 + SPW + 7) / 8) * 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // mode[5:0], slot_index[13:6], immediate[45:14], bank[47:46]
   input  logic [sbe_pkg::REQ_W-1:0] req_tdata,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // pc_advance[31:0], branch_taken[32], top_value[64:33],
   // stack_depth[64+SPW:65], status[66+SPW:65+SPW], zero fill above
   output logic [RSP_W-1:0]          rsp_tdata,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [sbe_pkg::CSR_W-1:0] csr_data
);
   import sbe_pkg::*;

   localparam int SAW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int LAW = (LOCAL_SLOTS > 1) ? $clog2(LOCAL_SLOTS) : 1;
   localparam int GAW = (GLOBAL_SLOTS > 1) ? $clog2(GLOBAL_SLOTS) : 1;
   localparam int TAW = (THREAD_SLOTS > 1) ? $clog2(THREAD_SLOTS) : 1;
   localparam int XAW = $clog2(SPECIAL_SLOTS);

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_RD_B  = 4'd2;
   localparam logic [3:0] S_RD_A  = 4'd3;
   localparam logic [3:0] S_EXEC  = 4'd4;
   localparam logic [3:0] S_DIV   = 4'd5;
   localparam logic [3:0] S_TOP   = 4'd6;
   localparam logic [3:0] S_TOPW  = 4'd7;

   logic [3:0]  state_ff, state_in;
   logic [8:0]  clr_ff, clr_in;
   logic [SPW-1:0] sp_ff, sp_in;
   logic [15:0] limit_ff, limit_in, guard_ff, guard_in;
   logic [LOCAL_SLOTS-1:0] lvalid_ff, lvalid_in;
   logic [5:0]  mode_ff;
   logic [7:0]  idx_ff;
   logic [31:0] imm_ff;
   logic [1:0]  bank_ff;
   logic [31:0] b_ff, a_ff, ld_ff, ld_in;
   logic [31:0] adv_ff, adv_in;
   logic        taken_ff, taken_in, ret_ff, ret_in;
   logic [1:0]  status_ff, status_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0] rsp_data_ff, rsp_data_in;

   logic        accept, fault, present;
   shape_type   shp;
   logic [SPW:0] sp_ext, sp_after;
   logic [SPW:0] s_addr_full;
   logic [SAW-1:0] s_rd_addr;
   logic        s_we;
   logic [SAW-1:0] s_wa;
   logic [31:0] s_wd, s_rd;
   logic        g_we, x_we, t_we, l_we;
   logic [GAW-1:0] g_wa, g_ra;
   logic [XAW-1:0] x_wa, x_ra;
   logic [TAW-1:0] t_wa, t_ra;
   logic [LAW-1:0] l_wa, l_ra;
   logic [31:0] g_wd, x_wd, t_wd, l_wd;
   logic [31:0] g_rd, x_rd, t_rd, l_rd;
   logic [7:0]  ra_idx;
   logic [31:0] alu_y, push_v, off, top_v;
   div_ctl_type div_ctl;
   logic        div_busy, div_done;
   logic [31:0] div_y;
   logic        in_g, in_l, in_t;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // decode of the held instruction
   assign shp    = shape(mode_ff, idx_ff[0]);
   assign sp_ext = {1'b0, sp_ff};
   assign fault  = shp.ok && ((sp_ext < {{(SPW-1){1'b0}}, shp.need}) ||
                   (sp_ext - {{(SPW-1){1'b0}}, shp.need} + {{(SPW-1){1'b0}}, shp.grow}
                    > (SPW+1)'(STACK_DEPTH)));
   assign sp_after = sp_ext - {{(SPW-1){1'b0}}, shp.need} + {{(SPW-1){1'b0}}, shp.grow};
   assign in_g = {1'b0, idx_ff} < 9'(GLOBAL_SLOTS);
   assign in_l = {1'b0, idx_ff} < 9'(LOCAL_SLOTS);
   assign in_t = {1'b0, idx_ff} < 9'(THREAD_SLOTS);

   // stack read address: top on accept and after execute, second below top in S_RD_B
   always_comb begin
      case (state_ff)
         S_RD_B:  s_addr_full = sp_ext - (SPW+1)'(2);
         default: s_addr_full = sp_ext - (SPW+1)'(1);
      endcase
   end
   assign s_rd_addr = s_addr_full[SAW-1:0];

   // bank reads use the request index while it is on the bus
   assign ra_idx = req_tdata[13:6];
   assign g_ra = GAW'(ra_idx);
   assign x_ra = XAW'(ra_idx);
   assign t_ra = TAW'(ra_idx);
   assign l_ra = LAW'(ra_idx);

   sbe_alu u_alu (.mode(mode_ff), .a(a_ff), .b(b_ff), .y(alu_y));

   assign div_ctl.start  = (state_ff == S_EXEC) && !fault &&
                           (mode_ff == OP_DIV || mode_ff == OP_MOD);
   assign div_ctl.is_mod = (mode_ff == OP_MOD);

   sbe_div u_div (
      .clock(clock), .reset(reset), .ctl(div_ctl), .dividend(a_ff), .divisor(b_ff),
      .busy(div_busy), .done(div_done), .result(div_y)
   );

   always_comb begin
      case (mode_ff)
         OP_DUP:  push_v = b_ff;
         OP_GLD, OP_LLD, OP_SLD, OP_TLD: push_v = ld_ff;
         OP_C32:  push_v = imm_ff;
         OP_C8:   push_v = sext8(idx_ff);
         OP_LNOT: push_v = {31'd0, b_ff == 32'd0};
         OP_NEG:  push_v = 32'd0 - b_ff;
         OP_NOT:  push_v = ~b_ff;
         default: push_v = alu_y;
      endcase
   end

   assign off = (mode_ff <= OP_JMP) ? sext8(idx_ff) : imm_ff;
   assign present = !rsp_valid_ff || rsp_tready;
   assign top_v = ret_ff ? b_ff :
                  ((status_ff == ST_DONE) || (sp_ff == '0)) ? 32'd0 : s_rd;

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      sp_in        = sp_ff;
      guard_in     = guard_ff;
      lvalid_in    = lvalid_ff;
      limit_in     = csr_valid ? csr_data : limit_ff;
      ld_in        = ld_ff;
      adv_in       = adv_ff;
      taken_in     = taken_ff;
      ret_in       = ret_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      s_we = 1'b0;
      s_wa = sp_after[SAW-1:0] - SAW'(1);
      s_wd = push_v;
      g_we = 1'b0; g_wa = GAW'(idx_ff); g_wd = b_ff;
      x_we = 1'b0; x_wa = XAW'(idx_ff); x_wd = imm_ff;
      t_we = 1'b0; t_wa = TAW'(idx_ff); t_wd = imm_ff;
      l_we = 1'b0; l_wa = LAW'(idx_ff); l_wd = b_ff;
      case (state_ff)
         S_CLEAR: begin
            // sweep the variable banks to zero
            g_we = (clr_ff < 9'(GLOBAL_SLOTS)); g_wa = GAW'(clr_ff); g_wd = 32'd0;
            x_we = 1'b1;                        x_wa = XAW'(clr_ff); x_wd = 32'd0;
            t_we = (clr_ff < 9'(THREAD_SLOTS)); t_wa = TAW'(clr_ff); t_wd = 32'd0;
            clr_in = clr_ff + 9'd1;
            if (clr_ff == 9'(SPECIAL_SLOTS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               state_in = S_RD_B;
            end
         end
         S_RD_B: begin
            // capture top of stack and the addressed variable
            case (mode_ff)
               OP_GLD:  ld_in = in_g ? g_rd : 32'd0;
               OP_LLD:  ld_in = (in_l && lvalid_ff[LAW'(idx_ff)]) ? l_rd : 32'd0;
               OP_SLD:  ld_in = x_rd;
               default: ld_in = in_t ? t_rd : 32'd0;
            endcase
            state_in = S_RD_A;
         end
         S_RD_A: begin
            state_in = S_EXEC;
         end
         S_EXEC: begin
            adv_in    = 32'd0;
            taken_in  = 1'b0;
            ret_in    = 1'b0;
            status_in = ST_OK;
            state_in  = S_TOP;
            if (mode_ff == OP_START) begin
               sp_in     = '0;
               lvalid_in = '0;
               guard_in  = limit_ff;
            end else if (mode_ff == OP_HOSTWR) begin
               g_wd = imm_ff;
               g_we = (bank_ff == BANK_GLOBAL) && in_g;
               x_we = (bank_ff == BANK_SPECIAL);
               t_we = (bank_ff == BANK_THREAD) && in_t;
            end else if (shp.ok) begin
               if (fault) begin
                  status_in = ST_FAULT;
               end else begin
                  sp_in  = sp_after[SPW-1:0];
                  adv_in = {29'd0, shp.len};
                  if (mode_ff == OP_DIV || mode_ff == OP_MOD) begin
                     state_in = S_DIV;
                  end else if (shp.grow != 2'd0) begin
                     s_we = 1'b1;
                  end
                  case (mode_ff)
                     OP_GST: g_we = in_g;
                     OP_LST: begin
                        l_we = in_l;
                        if (in_l) lvalid_in[LAW'(idx_ff)] = 1'b1;
                     end
                     OP_JZ, OP_LJZ, OP_JNZ, OP_LJNZ, OP_JMP, OP_LJMP: begin
                        if (mode_ff == OP_JMP || mode_ff == OP_LJMP) begin
                           taken_in = 1'b1;
                        end else if (mode_ff == OP_JZ || mode_ff == OP_LJZ) begin
                           taken_in = (b_ff == 32'd0);
                        end else begin
                           taken_in = (b_ff != 32'd0);
                        end
                        if (taken_in) adv_in = {29'd0, shp.len} + off;
                     end
                     OP_LOOP: begin
                        if (guard_ff <= 16'd1) begin
                           guard_in  = 16'd0;
                           sp_in     = '0;
                           status_in = ST_GUARD;
                        end else begin
                           guard_in = guard_ff - 16'd1;
                        end
                     end
                     OP_RET: begin
                        if (idx_ff[0]) begin
                           l_we = 1'b1;
                           l_wa = '0;
                           lvalid_in[0] = 1'b1;
                           ret_in = 1'b1;
                        end
                        sp_in     = '0;
                        status_in = ST_DONE;
                     end
                     default: ;
                  endcase
               end
            end
         end
         S_DIV: begin
            // write the quotient or remainder over the new top
            if (div_done) begin
               s_we     = 1'b1;
               s_wa     = s_rd_addr;
               s_wd     = div_y;
               state_in = S_TOP;
            end
         end
         S_TOP: begin
            state_in = S_TOPW;
         end
         S_TOPW: begin
            // hold until the result register is free
            if (present) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_W'({status_ff, sp_ff, top_v, taken_ff, adv_ff});
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   sbe_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_stack (
      .clock(clock), .wr_en(s_we), .wr_addr(s_wa), .wr_data(s_wd),
      .rd_addr(s_rd_addr), .rd_data(s_rd)
   );
   sbe_ram #(.WIDTH(32), .DEPTH(GLOBAL_SLOTS)) u_global (
      .clock(clock), .wr_en(g_we), .wr_addr(g_wa), .wr_data(g_wd),
      .rd_addr(g_ra), .rd_data(g_rd)
   );
   sbe_ram #(.WIDTH(32), .DEPTH(SPECIAL_SLOTS)) u_special (
      .clock(clock), .wr_en(x_we), .wr_addr(x_wa), .wr_data(x_wd),
      .rd_addr(x_ra), .rd_data(x_rd)
   );
   sbe_ram #(.WIDTH(32), .DEPTH(THREAD_SLOTS)) u_thread (
      .clock(clock), .wr_en(t_we), .wr_addr(t_wa), .wr_data(t_wd),
      .rd_addr(t_ra), .rd_data(t_rd)
   );
   sbe_ram #(.WIDTH(32), .DEPTH(LOCAL_SLOTS)) u_local (
      .clock(clock), .wr_en(l_we), .wr_addr(l_wa), .wr_data(l_wd),
      .rd_addr(l_ra), .rd_data(l_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= 9'd0;
         sp_ff        <= '0;
         limit_ff     <= GUARD_RESET;
         guard_ff     <= GUARD_RESET;
         lvalid_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         sp_ff        <= sp_in;
         limit_ff     <= limit_in;
         guard_ff     <= guard_in;
         lvalid_ff    <= lvalid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (accept) begin
         mode_ff <= req_tdata[5:0];
         idx_ff  <= req_tdata[13:6];
         imm_ff  <= req_tdata[45:14];
         bank_ff <= req_tdata[47:46];
      end
      if (state_ff == S_RD_B) b_ff <= s_rd;
      if (state_ff == S_RD_A) a_ff <= s_rd;
      ld_ff       <= ld_in;
      adv_ff      <= adv_in;
      taken_ff    <= taken_in;
      ret_ff      <= ret_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
   end

   a_sp_range: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= SPW'(STACK_DEPTH))
      else $error("stack pointer beyond depth");
   a_div_state: assert property (@(posedge clock) disable iff (reset)
      div_busy |-> state_ff == S_DIV)
      else $error("divider running outside divide state");
   a_fault_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EXEC && fault) |=> $stable(sp_ff))
      else $error("stack fault moved the stack pointer");
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == S_RD_B)
      else $error("accepted request not sequenced");
endmodule

// ===== tb/tb_stack_bytecode_execute_unit.sv =====
// Self-checking testbench of stack_bytecode_execute_unit: drives decoded instructions,
// predicts every result in-line and compares it field by field. Depends on sbe_pkg and the RTL.
`timescale 1ns / 1ps
module tb_stack_bytecode_execute_unit;
   import sbe_pkg::*;

   localparam int DEPTH_MAX = 64;
   localparam int RSP_BITS  = 80;
   localparam int DRAIN_CYC = 60;   // a divide plus the pipeline, with margin
   localparam int HOLD_CYC  = 300;  // long receiver hold-off
   localparam int QUEUE_LEN = 2048;

   typedef struct packed {
      logic [1:0]  bank;
      logic [31:0] imm;
      logic [7:0]  slot;
      logic [5:0]  mode;
   } instr_t;

   typedef struct {
      logic [31:0] adv;
      logic        taken;
      logic [31:0] top;
      logic [6:0]  depth;
      logic [1:0]  status;
   } outcome_t;

   logic clock, reset;
   logic req_tvalid, req_tready, rsp_tvalid, rsp_tready;
   logic [REQ_W-1:0] req_tdata;      // mode, slot_index, immediate, bank from bit 0 up
   logic [RSP_BITS-1:0] rsp_tdata;   // pc_advance, branch_taken, top_value, stack_depth, status
   logic csr_valid, csr_ready;
   logic [CSR_W-1:0] csr_data;

   stack_bytecode_execute_unit i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   // Machine state mirror
   logic [31:0] stk [DEPTH_MAX];
   int          sp;
   logic [31:0] locals [LOCAL_SLOTS_DEF];
   logic        local_ok [LOCAL_SLOTS_DEF];
   logic [31:0] globals [GLOBAL_SLOTS_DEF];
   logic [31:0] specials [SPECIAL_SLOTS];
   logic [31:0] threads [THREAD_SLOTS_DEF];
   logic [15:0] guard_count, guard_limit;

   // pending items and predictions, kept as rings with write and read counts
   instr_t   pend_mem [QUEUE_LEN];
   int       pend_wr, pend_rd;
   outcome_t exp_mem [QUEUE_LEN];
   int       exp_wr, exp_rd;
   int sender_idle_pct, receiver_stall_pct;
   int hold_request, hold_seen, hold_left;
   int errors, n_sent, n_checked, n_faults, n_trips, n_returns;
   int gen_depth;

   // Stack use of an opcode: pops, pushes and encoded length; 0 for unused modes.
   function automatic bit op_shape(input logic [5:0] m, input logic [7:0] s,
                                   output int need, output int grow, output int len);
      need = 0; grow = 0; len = 1;
      case (m)
         OP_NOP, OP_LOOP: ;
         OP_POP: need = 1;
         OP_DUP: begin need = 1; grow = 2; end
         OP_GLD, OP_LLD, OP_SLD, OP_TLD, OP_C8: begin grow = 1; len = 2; end
         OP_GST, OP_LST, OP_JZ, OP_JNZ: begin need = 1; len = 2; end
         OP_C32: begin grow = 1; len = 5; end
         OP_LNOT, OP_NEG, OP_NOT: begin need = 1; grow = 1; end
         OP_JMP: len = 2;
         OP_LJZ, OP_LJNZ: begin need = 1; len = 5; end
         OP_LJMP: len = 5;
         OP_RET: need = s[0];
         default: begin
            if (m >= OP_ADD && m <= OP_NE) begin
               need = 2; grow = 1;
            end else return 0;
         end
      endcase
      return 1;
   endfunction

   function automatic logic [31:0] arith(input logic [5:0] m, input logic [31:0] a,
                                         input logic [31:0] b);
      case (m)
         OP_ADD: return a + b;
         OP_SUB: return a - b;
         OP_MUL: return a * b;
         OP_DIV: begin
            if (b == 0) return 0;
            if (b == 32'hFFFF_FFFF) return -a;   // also wraps the most negative value
            return $signed(a) / $signed(b);
         end
         OP_MOD: begin
            if (b == 0 || b == 1 || b == 32'hFFFF_FFFF) return 0;
            return $signed(a) % $signed(b);
         end
         OP_AND: return a & b;
         OP_OR:  return a | b;
         OP_XOR: return a ^ b;
         OP_SHR: return $signed(a) >>> b[4:0];
         OP_SHL: return a << b[4:0];
         OP_LAND: return {31'd0, a != 0 && b != 0};
         OP_LOR:  return {31'd0, a != 0 || b != 0};
         OP_LT: return {31'd0, $signed(a) < $signed(b)};
         OP_LE: return {31'd0, $signed(a) <= $signed(b)};
         OP_GT: return {31'd0, $signed(a) > $signed(b)};
         OP_GE: return {31'd0, $signed(a) >= $signed(b)};
         OP_EQ: return {31'd0, a == b};
         default: return {31'd0, a != b};
      endcase
   endfunction

   function automatic logic [31:0] read_local(input logic [7:0] i);
      return (i < LOCAL_SLOTS_DEF && local_ok[i]) ? locals[i] : 32'd0;
   endfunction

   function automatic void write_local(input logic [7:0] i, input logic [31:0] v);
      if (i < LOCAL_SLOTS_DEF) begin
         locals[i] = v;
         local_ok[i] = 1'b1;
      end
   endfunction

   // Place a value on the mirrored stack.
   function automatic void push_val(input logic [31:0] v);
      stk[sp] = v;
      sp = sp + 1;
   endfunction

   // Execute one instruction on the mirror and return what the unit must report.
   function automatic outcome_t execute_instr(input instr_t it);
      outcome_t r;
      int need, grow, len;
      logic [31:0] a, b, off;
      bit ret_value;
      r = '{default: '0};
      a = 0; b = 0; ret_value = 0;
      if (it.mode == OP_START) begin
         sp = 0;
         foreach (local_ok[i]) local_ok[i] = 1'b0;
         guard_count = guard_limit;
      end else if (it.mode == OP_HOSTWR) begin
         if (it.bank == BANK_GLOBAL) globals[it.slot] = it.imm;
         else if (it.bank == BANK_SPECIAL) specials[it.slot] = it.imm;
         else if (it.bank == BANK_THREAD && it.slot < THREAD_SLOTS_DEF)
            threads[it.slot] = it.imm;
      end else if (op_shape(it.mode, it.slot, need, grow, len)) begin
         if (sp < need || sp - need + grow > DEPTH_MAX) begin
            r.status = ST_FAULT;
         end else begin
            if (need >= 1) b = stk[sp-1];
            if (need >= 2) a = stk[sp-2];
            sp -= need;
            r.adv = 32'(len);
            case (it.mode)
               OP_DUP: begin stk[sp] = b; stk[sp+1] = b; sp += 2; end
               OP_GLD: push_val(globals[it.slot]);
               OP_GST: globals[it.slot] = b;
               OP_LLD: push_val(read_local(it.slot));
               OP_LST: write_local(it.slot, b);
               OP_SLD: push_val(specials[it.slot]);
               OP_TLD: push_val((it.slot < THREAD_SLOTS_DEF) ? threads[it.slot] : 32'd0);
               OP_C32: push_val(it.imm);
               OP_C8:  push_val({{24{it.slot[7]}}, it.slot});
               OP_LNOT: push_val({31'd0, b == 0});
               OP_NEG: push_val(-b);
               OP_NOT: push_val(~b);
               OP_JZ, OP_JNZ, OP_JMP, OP_LJZ, OP_LJNZ, OP_LJMP: begin
                  off = (it.mode <= OP_JMP) ? {{24{it.slot[7]}}, it.slot} : it.imm;
                  if (it.mode == OP_JMP || it.mode == OP_LJMP) r.taken = 1;
                  else if (it.mode == OP_JZ || it.mode == OP_LJZ) r.taken = (b == 0);
                  else r.taken = (b != 0);
                  if (r.taken) r.adv = 32'(len) + off;
               end
               OP_LOOP: begin
                  if (guard_count <= 1) begin
                     guard_count = 0;
                     sp = 0;
                     r.status = ST_GUARD;
                  end else guard_count--;
               end
               OP_RET: begin
                  if (it.slot[0]) begin
                     write_local(0, b);
                     ret_value = 1;
                  end
                  sp = 0;
                  r.status = ST_DONE;
               end
               OP_NOP, OP_POP: ;
               default: push_val(arith(it.mode, a, b));
            endcase
         end
      end
      if (ret_value) r.top = b;
      else if (r.status != ST_DONE && sp > 0) r.top = stk[sp-1];
      r.depth = 7'(sp);
      return r;
   endfunction

   task automatic add_instr(input logic [5:0] m, input logic [7:0] s,
                            input logic [31:0] imm, input logic [1:0] bk);
      int need, grow, len;
      pend_mem[pend_wr % QUEUE_LEN] = '{mode: m, slot: s, imm: imm, bank: bk};
      pend_wr++;
      // rough depth estimate for steering the random mix
      if (m == OP_START || m == OP_RET) gen_depth = 0;
      else if (op_shape(m, s, need, grow, len) && gen_depth >= need
               && gen_depth - need + grow <= DEPTH_MAX)
         gen_depth = gen_depth - need + grow;
   endtask

   function automatic logic [31:0] pick_value();
      case ($urandom_range(7))
         0: return 0;
         1: return 1;
         2: return 32'hFFFF_FFFF;
         3: return 32'h8000_0000;
         4: return 32'h7FFF_FFFF;
         5: return $urandom_range(40);
         default: return $urandom;
      endcase
   endfunction

   // Mostly well-formed code with random operands; a little pure noise.
   task automatic add_random_instr();
      int r;
      logic [5:0] m;
      logic [7:0] s;
      r = $urandom_range(99);
      s = 8'($urandom);
      if (r < 5) m = 6'($urandom_range(63));
      else if (r < 8) m = OP_START;
      else if (r < 10) m = OP_RET;
      else if (r < 15) m = OP_LOOP;
      else if (r < 19) m = OP_HOSTWR;
      else if (r < 21) m = 6'($urandom_range(63, 42));
      else if (r < 23) m = OP_NOP;
      else if (gen_depth < 2 || ($urandom_range(99) < 45 && gen_depth < DEPTH_MAX + 2)) begin
         case ($urandom_range(7))
            0: m = OP_GLD;
            1: m = OP_LLD;
            2: m = OP_SLD;
            3: m = OP_TLD;
            4: m = OP_DUP;
            5: m = OP_C8;
            default: m = OP_C32;
         endcase
      end else begin
         case ($urandom_range(5))
            0: m = OP_GST;
            1: m = OP_LST;
            2: m = OP_POP;
            3: m = 6'($urandom_range(OP_LJMP, OP_JZ));
            4: m = 6'($urandom_range(OP_NOT, OP_NEG - 9));  // logical not .. bitwise not
            default: m = 6'($urandom_range(OP_NOT, OP_ADD));
         endcase
      end
      if ((m == OP_LLD || m == OP_LST) && $urandom_range(3) != 0) s = 8'($urandom_range(35));
      if ((m == OP_TLD || m == OP_HOSTWR) && $urandom_range(1)) s = 8'($urandom_range(70));
      add_instr(m, s, pick_value(), 2'($urandom));
   endtask

   task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%08h, got 0x%08h", name, want, got);
         errors++;
      end
   endtask

   task automatic write_guard_limit(input logic [15:0] v);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      guard_limit = v;
      csr_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (pend_rd != pend_wr || req_tvalid || exp_rd != exp_wr)
         @(posedge clock);
      repeat (DRAIN_CYC) @(posedge clock);
   endtask

   always begin
      clock = 1'b1; #6;
      clock = 1'b0; #6;
   end

   // Sender: hold the item until it transfers, then offer the next one or idle.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) begin
            exp_mem[exp_wr % QUEUE_LEN] = execute_instr(req_tdata);
            exp_wr++;
            n_sent++;
         end
         if (pend_rd != pend_wr && $urandom_range(99) >= sender_idle_pct) begin
            req_tvalid <= 1'b1;
            req_tdata  <= pend_mem[pend_rd % QUEUE_LEN];
            pend_rd++;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver: compare every transfer with the oldest prediction; stall at random.
   always @(posedge clock) begin
      outcome_t e;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (exp_rd == exp_wr) begin
               $error("unexpected result 0x%020h", rsp_tdata);
               errors++;
            end else begin
               e = exp_mem[exp_rd % QUEUE_LEN];
               exp_rd++;
               check_field("pc_advance", e.adv, rsp_tdata[31:0]);
               check_field("branch_taken", e.taken, rsp_tdata[32]);
               check_field("top_value", e.top, rsp_tdata[64:33]);
               check_field("stack_depth", e.depth, rsp_tdata[71:65]);
               check_field("status", e.status, rsp_tdata[73:72]);
               check_field("fill", 0, rsp_tdata[79:74]);
               if (e.status == ST_FAULT) n_faults++;
               if (e.status == ST_GUARD) n_trips++;
               if (e.status == ST_DONE) n_returns++;
               n_checked++;
            end
         end
         if (hold_seen != hold_request) begin
            hold_seen = hold_request;
            hold_left = HOLD_CYC;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
         end
      end
   end

   initial begin
      #(10_000_000);
      $display("stack_bytecode_execute_unit: mismatch");
      $finish;
   end

   initial begin
      int idle_of [5]  = '{0, 60, 0, 34, 0};
      int stall_of [5] = '{0, 0, 60, 34, 0};
      logic [15:0] limit_of [5] = '{16'd1, 16'd65535, 16'd4, 16'd2, 16'd300};
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      csr_valid = 1'b0;
      csr_data = '0;
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      hold_request = 0; hold_seen = 0; hold_left = 0;
      errors = 0; n_sent = 0; n_checked = 0; n_faults = 0; n_trips = 0; n_returns = 0;
      pend_wr = 0; pend_rd = 0; exp_wr = 0; exp_rd = 0;
      gen_depth = 0;
      sp = 0;
      foreach (stk[i]) stk[i] = 0;
      foreach (locals[i]) begin locals[i] = 0; local_ok[i] = 0; end
      foreach (globals[i]) globals[i] = 0;
      foreach (specials[i]) specials[i] = 0;
      foreach (threads[i]) threads[i] = 0;
      guard_limit = GUARD_RESET;
      guard_count = GUARD_RESET;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: faults, wrapping division corners, branch extremes, dropped writes.
      add_instr(OP_POP, 0, 0, 0);                     // underflow on empty stack
      add_instr(OP_C32, 0, 32'h8000_0000, 0);
      add_instr(OP_C8, 8'hFF, 0, 3);
      add_instr(OP_DIV, 0, 0, 0);                     // most negative / -1 wraps
      add_instr(OP_C8, 8'h80, 0, 0);
      add_instr(OP_C8, 8'h00, 0, 0);
      add_instr(OP_MOD, 0, 0, 0);                     // modulo by zero
      add_instr(OP_DIV, 0, 0, 0);
      add_instr(OP_C32, 0, 32'd33, 0);
      add_instr(OP_SHL, 0, 0, 0);                     // amount masked to 1
      add_instr(OP_JMP, 8'h80, 0, 0);
      add_instr(OP_JMP, 8'h7F, 0, 0);
      add_instr(OP_LJMP, 0, 32'h8000_0000, 0);
      add_instr(OP_JZ, 0, 0, 0);
      add_instr(OP_LLD, 8'd200, 0, 0);                // local out of range reads zero
      add_instr(OP_HOSTWR, 8'd100, 32'hDEAD_BEEF, BANK_THREAD);  // dropped
      add_instr(OP_HOSTWR, 8'd5, 32'h1234_5678, 2'd3);           // dropped
      add_instr(OP_HOSTWR, 8'd255, 32'hCAFE_0001, BANK_SPECIAL);
      add_instr(OP_SLD, 8'd255, 0, 0);
      add_instr(OP_TLD, 8'd100, 0, 0);
      add_instr(6'd63, 8'hFF, 32'hFFFF_FFFF, 2'd3);   // unused mode
      add_instr(OP_LOOP, 0, 0, 0);
      add_instr(OP_RET, 8'h01, 0, 0);                 // integer return
      add_instr(OP_RET, 8'h01, 0, 0);                 // integer return on empty: fault
      add_instr(OP_START, 0, 0, 0);
      wait_drained();

      for (int ph = 0; ph < 5; ph++) begin
         write_guard_limit(limit_of[ph]);
         sender_idle_pct = idle_of[ph];
         receiver_stall_pct = stall_of[ph];
         add_instr(OP_START, 0, 0, 0);
         if (ph == 4) begin
            // fill the stack to overflow, then keep offering while the receiver holds off
            repeat (DEPTH_MAX + 2) add_instr(OP_C32, 0, $urandom, 2'($urandom));
            hold_request++;
         end
         repeat (225) add_random_instr();
         wait_drained();
      end

      $display("covered %0d instructions, %0d results checked", n_sent, n_checked);
      $display("stack faults %0d, guard trips %0d, returns %0d", n_faults, n_trips, n_returns);
      if (errors == 0) begin
         $display("stack_bytecode_execute_unit: match");
      end else begin
         $display("stack_bytecode_execute_unit: mismatch");
      end
      $finish;
   end

endmodule
